@@ hw/rtl/erts_pkg.sv @@
// shared types and constants of the expert route threshold skip block
`default_nettype none

package erts_pkg;

   // sizing
   localparam int MAX_EXPERTS = 16;
   localparam int NUM_LAYERS  = 256;
   localparam int STORE_DEPTH = 2 * NUM_LAYERS;
   localparam int IDX_W       = $clog2(MAX_EXPERTS);
   localparam int CNT_W       = $clog2(MAX_EXPERTS + 2);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // field widths
   localparam int FUNC_W   = 2;
   localparam int FAMILY_W = 2;
   localparam int LAYER_W  = 8;
   localparam int THR_W    = 17;
   localparam int MK_W     = 9;
   localparam int WEIGHT_W = 32;
   localparam int MASK_W   = 16;
   localparam int SKIP_W   = 5;
   localparam int STATUS_W = 2;
   localparam int SUM_W    = WEIGHT_W + IDX_W;
   localparam int PROD_W   = THR_W + SUM_W;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_WEIGHT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   // family codes
   localparam logic [FAMILY_W-1:0] FAMILY_CONTROL = 2'd0;
   localparam logic [FAMILY_W-1:0] FAMILY_CONTENT = 2'd1;
   localparam logic [FAMILY_W-1:0] FAMILY_MEDIA   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd3;

   // policy limits
   localparam logic [THR_W-1:0] THR_ONE  = 17'd65536;
   localparam logic [MK_W-1:0]  MK_LIMIT = 9'd256;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [FAMILY_W-1:0] family;
      logic [LAYER_W-1:0]  layer;
      logic [THR_W-1:0]    threshold;
      logic [MK_W-1:0]     keep_floor;
      logic [WEIGHT_W-1:0] weight;
      logic                weight_bad;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0]   keep_mask;
      logic [SKIP_W-1:0]   skipped_count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_POLICY,
      ST_SCAN_KEEP,
      ST_SCAN_SEL
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/expert_route_threshold_skip.sv @@
// top level: policy store, weight buffer and event decision sequencer
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  erts_pkg::req_type
//  rsp      out        rsp_valid/rsp_stall  erts_pkg::rsp_type
//
// a weight that is not last, and a policy write, leave the sequencer in its idle state
// a last weight runs a policy lookup and the threshold scan, plus a further scan for each expert
//   added by the minimum keep search; one shared compare unit and one buffer read port serialize these
// a clear transaction and reset both start a clearing pass over the policy store,
//   one entry a cycle, during which req_stall stays high
// a result waits in the output register; req is taken only while that register is free or
//   being emptied
`default_nettype none

module expert_route_threshold_skip (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire erts_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output erts_pkg::rsp_type      rsp_data
);

   typedef struct packed {
      logic [erts_pkg::THR_W-1:0] thr;
      logic [erts_pkg::MK_W-1:0]  mk;
   } pol_type;

   // policy store and weight buffer
   pol_type                          pol_mem [erts_pkg::STORE_DEPTH];
   logic [erts_pkg::WEIGHT_W-1:0]    buf_mem [erts_pkg::MAX_EXPERTS];

   erts_pkg::state_type              state_ff, state_in;
   logic [erts_pkg::ADDR_W-1:0]      clr_ff, clr_in;

   // event accumulators
   logic [erts_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [erts_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic                             bad_ff, bad_in;

   // event snapshot taken on the last weight
   logic [erts_pkg::CNT_W-1:0]       ev_n_ff, ev_n_in;
   logic [erts_pkg::SUM_W-1:0]       ev_sum_ff, ev_sum_in;
   logic                             ev_bad_ff, ev_bad_in;
   logic [erts_pkg::FAMILY_W-1:0]    ev_family_ff, ev_family_in;
   logic [erts_pkg::LAYER_W-1:0]     ev_layer_ff, ev_layer_in;

   // decision working registers
   logic [erts_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [erts_pkg::CNT_W-1:0]       mk_ff, mk_in;
   logic [erts_pkg::MAX_EXPERTS-1:0] keep_ff, keep_in;
   logic [erts_pkg::CNT_W-1:0]       kept_ff, kept_in;
   logic [erts_pkg::CNT_W-1:0]       scan_ff, scan_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic [erts_pkg::IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                             found_ff, found_in;
   logic [erts_pkg::IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [erts_pkg::WEIGHT_W-1:0]    best_w_ff, best_w_in;

   // memory ports
   pol_type                          pol_rd_ff;
   logic [erts_pkg::WEIGHT_W-1:0]    buf_rd_ff;
   logic                             pol_we;
   logic [erts_pkg::ADDR_W-1:0]      pol_waddr;
   pol_type                          pol_wdata;
   logic [erts_pkg::ADDR_W-1:0]      pol_raddr;
   logic                             buf_we;
   logic [erts_pkg::IDX_W-1:0]       buf_raddr;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   erts_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   // shared magnitude compare
   logic [erts_pkg::PROD_W-1:0]      cmp_a, cmp_b;
   logic                             cmp_ge;

   logic                             req_accept;
   logic                             fam_ok;
   logic                             layer_ok;
   logic                             ev_fam_ok;
   logic                             ev_layer_ok;
   logic                             wr_ok;
   logic [erts_pkg::ADDR_W-1:0]      req_addr;
   logic [erts_pkg::CNT_W-1:0]       cnt_new;
   logic [erts_pkg::SUM_W-1:0]       sum_new;
   logic                             bad_new;
   logic [erts_pkg::MAX_EXPERTS-1:0] all_mask;
   logic [erts_pkg::MAX_EXPERTS-1:0] keep_new;
   logic [erts_pkg::CNT_W-1:0]       kept_new;
   logic [erts_pkg::MK_W-1:0]        mk_lo;
   logic                             scan_end;

   assign req_stall  = (state_ff != erts_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // policy entry of the incoming transaction: content rows first, media rows after
   assign fam_ok   = (req_data.family == erts_pkg::FAMILY_CONTENT) ||
                     (req_data.family == erts_pkg::FAMILY_MEDIA);
   assign layer_ok = ({1'b0, req_data.layer} < erts_pkg::ADDR_W'(erts_pkg::NUM_LAYERS));
   assign req_addr = (req_data.family == erts_pkg::FAMILY_MEDIA)
                   ? erts_pkg::ADDR_W'(erts_pkg::NUM_LAYERS) + erts_pkg::ADDR_W'(req_data.layer)
                   : erts_pkg::ADDR_W'(req_data.layer);
   assign pol_raddr = req_addr;

   assign wr_ok = fam_ok && layer_ok && (req_data.layer != '0) &&
                  (req_data.threshold <= erts_pkg::THR_ONE) &&
                  (req_data.keep_floor != '0) && (req_data.keep_floor <= erts_pkg::MK_LIMIT);

   assign ev_fam_ok   = (ev_family_ff == erts_pkg::FAMILY_CONTENT) ||
                        (ev_family_ff == erts_pkg::FAMILY_MEDIA);
   assign ev_layer_ok = ({1'b0, ev_layer_ff} < erts_pkg::ADDR_W'(erts_pkg::NUM_LAYERS));

   assign scan_end = (scan_ff == ev_n_ff) && !rd_vld_ff;

   // mask with one bit for every expert of the event
   always_comb begin
      for (int i = 0; i < erts_pkg::MAX_EXPERTS; i++) begin
         all_mask[i] = (erts_pkg::CNT_W'(i) < ev_n_ff);
      end
   end

   // keep scan: weight * 65536 against threshold * sum; search: best weight against candidate
   always_comb begin
      if (state_ff == erts_pkg::ST_SCAN_SEL) begin
         cmp_a = erts_pkg::PROD_W'(best_w_ff);
         cmp_b = erts_pkg::PROD_W'(buf_rd_ff);
      end else begin
         cmp_a = erts_pkg::PROD_W'({buf_rd_ff, 16'h0000});
         cmp_b = prod_ff;
      end
   end
   assign cmp_ge = (cmp_a >= cmp_b);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      bad_in       = bad_ff;
      ev_n_in      = ev_n_ff;
      ev_sum_in    = ev_sum_ff;
      ev_bad_in    = ev_bad_ff;
      ev_family_in = ev_family_ff;
      ev_layer_in  = ev_layer_ff;
      prod_in      = prod_ff;
      mk_in        = mk_ff;
      keep_in      = keep_ff;
      kept_in      = kept_ff;
      scan_in      = scan_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_w_in    = best_w_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pol_we       = 1'b0;
      pol_waddr    = req_addr;
      pol_wdata    = '{thr: req_data.threshold, mk: req_data.keep_floor};
      buf_we       = 1'b0;
      buf_raddr    = scan_ff[erts_pkg::IDX_W-1:0];
      keep_new     = keep_ff;
      kept_new     = kept_ff;
      mk_lo        = '0;

      // accumulator update for a weight transaction; count saturates one past the buffer
      if (cnt_ff < erts_pkg::CNT_W'(erts_pkg::MAX_EXPERTS)) begin
         cnt_new = cnt_ff + 1'b1;
         sum_new = sum_ff + erts_pkg::SUM_W'(req_data.weight);
      end else begin
         cnt_new = erts_pkg::CNT_W'(erts_pkg::MAX_EXPERTS + 1);
         sum_new = sum_ff;
      end
      bad_new = bad_ff || req_data.weight_bad;

      unique case (state_ff)
         erts_pkg::ST_CLEAR: begin
            pol_we    = 1'b1;
            pol_waddr = clr_ff;
            pol_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == erts_pkg::ADDR_W'(erts_pkg::STORE_DEPTH - 1)) begin
               state_in = erts_pkg::ST_IDLE;
            end
         end

         erts_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_data.func)
                  erts_pkg::FUNC_WEIGHT: begin
                     buf_we = (cnt_ff < erts_pkg::CNT_W'(erts_pkg::MAX_EXPERTS));
                     if (req_data.last) begin
                        ev_n_in      = cnt_new;
                        ev_sum_in    = sum_new;
                        ev_bad_in    = bad_new;
                        ev_family_in = req_data.family;
                        ev_layer_in  = req_data.layer;
                        cnt_in       = '0;
                        sum_in       = '0;
                        bad_in       = 1'b0;
                        state_in     = erts_pkg::ST_POLICY;
                     end else begin
                        cnt_in = cnt_new;
                        sum_in = sum_new;
                        bad_in = bad_new;
                     end
                  end
                  erts_pkg::FUNC_WRITE: begin
                     pol_we                    = wr_ok;
                     rsp_valid_in              = 1'b1;
                     rsp_data_in.keep_mask     = '0;
                     rsp_data_in.skipped_count = '0;
                     rsp_data_in.status        = wr_ok ? erts_pkg::STATUS_OK
                                                       : erts_pkg::STATUS_INVALID;
                  end
                  erts_pkg::FUNC_CLEAR: begin
                     clr_in   = '0;
                     state_in = erts_pkg::ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         erts_pkg::ST_POLICY: begin
            rsp_data_in.keep_mask     = erts_pkg::MASK_W'(all_mask);
            rsp_data_in.skipped_count = '0;
            rsp_data_in.status        = erts_pkg::STATUS_OK;
            if (ev_n_ff > erts_pkg::CNT_W'(erts_pkg::MAX_EXPERTS)) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.keep_mask = '0;
               rsp_data_in.status    = erts_pkg::STATUS_TOO_MANY;
               state_in              = erts_pkg::ST_IDLE;
            end else if (!ev_fam_ok || !ev_layer_ok || (pol_rd_ff.thr == '0)) begin
               rsp_valid_in = 1'b1;
               state_in     = erts_pkg::ST_IDLE;
            end else if (ev_bad_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.keep_mask = '0;
               rsp_data_in.status    = erts_pkg::STATUS_BAD;
               state_in              = erts_pkg::ST_IDLE;
            end else if (ev_sum_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = erts_pkg::ST_IDLE;
            end else begin
               prod_in = erts_pkg::PROD_W'(pol_rd_ff.thr) * erts_pkg::PROD_W'(ev_sum_ff);
               // minimum keep clamped to one .. event size
               mk_lo   = (pol_rd_ff.mk == '0) ? erts_pkg::MK_W'(1) : pol_rd_ff.mk;
               mk_in   = (mk_lo > erts_pkg::MK_W'(ev_n_ff)) ? ev_n_ff
                                                            : erts_pkg::CNT_W'(mk_lo);
               keep_in  = '0;
               kept_in  = '0;
               scan_in  = '0;
               state_in = erts_pkg::ST_SCAN_KEEP;
            end
         end

         erts_pkg::ST_SCAN_KEEP: begin
            if (scan_ff < ev_n_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff[erts_pkg::IDX_W-1:0];
               scan_in   = scan_ff + 1'b1;
            end
            if (rd_vld_ff && cmp_ge) begin
               keep_in[rd_idx_ff] = 1'b1;
               kept_in            = kept_ff + 1'b1;
            end
            if (scan_end) begin
               if (kept_ff >= mk_ff) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.keep_mask     = erts_pkg::MASK_W'(keep_ff);
                  rsp_data_in.skipped_count = erts_pkg::SKIP_W'(ev_n_ff - kept_ff);
                  rsp_data_in.status        = erts_pkg::STATUS_OK;
                  state_in                  = erts_pkg::ST_IDLE;
               end else begin
                  scan_in  = '0;
                  found_in = 1'b0;
                  state_in = erts_pkg::ST_SCAN_SEL;
               end
            end
         end

         erts_pkg::ST_SCAN_SEL: begin
            if (scan_ff < ev_n_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff[erts_pkg::IDX_W-1:0];
               scan_in   = scan_ff + 1'b1;
            end
            // strictly larger wins, so ties keep the lowest index
            if (rd_vld_ff && !keep_ff[rd_idx_ff] && (!found_ff || !cmp_ge)) begin
               found_in    = 1'b1;
               best_idx_in = rd_idx_ff;
               best_w_in   = buf_rd_ff;
            end
            if (scan_end) begin
               if (found_ff) begin
                  keep_new[best_idx_ff] = 1'b1;
                  kept_new              = kept_ff + 1'b1;
               end
               keep_in = keep_new;
               kept_in = kept_new;
               if (!found_ff || (kept_new >= mk_ff)) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.keep_mask     = erts_pkg::MASK_W'(keep_new);
                  rsp_data_in.skipped_count = erts_pkg::SKIP_W'(ev_n_ff - kept_new);
                  rsp_data_in.status        = erts_pkg::STATUS_OK;
                  state_in                  = erts_pkg::ST_IDLE;
               end else begin
                  scan_in  = '0;
                  found_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = erts_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= erts_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         bad_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         bad_ff       <= bad_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ev_n_ff      <= ev_n_in;
      ev_sum_ff    <= ev_sum_in;
      ev_bad_ff    <= ev_bad_in;
      ev_family_ff <= ev_family_in;
      ev_layer_ff  <= ev_layer_in;
      prod_ff      <= prod_in;
      mk_ff        <= mk_in;
      keep_ff      <= keep_in;
      kept_ff      <= kept_in;
      scan_ff      <= scan_in;
      rd_idx_ff    <= rd_idx_in;
      found_ff     <= found_in;
      best_idx_ff  <= best_idx_in;
      best_w_ff    <= best_w_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // policy store, one write and one registered read
   always_ff @(posedge clock) begin
      if (pol_we) begin
         pol_mem[pol_waddr] <= pol_wdata;
      end
      pol_rd_ff <= pol_mem[pol_raddr];
   end

   // weight buffer, one write and one registered read
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[cnt_ff[erts_pkg::IDX_W-1:0]] <= req_data.weight;
      end
      buf_rd_ff <= buf_mem[buf_raddr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/erts_checker.sv @@
// port checker for the expert route threshold skip block, with its bind
`default_nettype none

module erts_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire erts_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire erts_pkg::rsp_type rsp_data
);

   logic req_accept;
   logic no_result;

   assign req_accept = req_valid && !req_stall;
   assign no_result  = (req_data.func != erts_pkg::FUNC_WRITE) &&
                       !((req_data.func == erts_pkg::FUNC_WEIGHT) && req_data.last);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // clearing pass after reset blocks the request side
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // a policy write answers in the next cycle
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.func == erts_pkg::FUNC_WRITE) |=> rsp_valid)
      else $error("policy write gave no result");

   // a transaction without result leaves the output empty
   a_silent: assert property (@(posedge clock) disable iff (reset)
      req_accept && no_result |=> !rsp_valid)
      else $error("result without cause");

endmodule

bind expert_route_threshold_skip erts_checker u_erts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ tb/expert_route_threshold_skip_test.sv @@
// self-checking testbench for the expert route threshold skip block
`timescale 1ns / 100ps

module expert_route_threshold_skip_test;
   import erts_pkg::*;

   // run sizing
   localparam int ITEM_TARGET    = 1550;
   localparam int HOT_LAYERS     = 6;
   localparam int WATCHDOG_LIMIT = 20000;  // quiet cycles before the run is abandoned
   localparam int SETTLE_CYCLES  = 600;    // covers a full clearing pass of the policy store
   localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
   localparam int MAX_REPORTS    = 40;

   // codes the package leaves unnamed
   localparam logic [FUNC_W-1:0]   FUNC_UNUSED   = 2'd3;
   localparam logic [FAMILY_W-1:0] FAMILY_UNUSED = 2'd3;

   typedef enum int unsigned {
      W_WIDE,
      W_NARROW,
      W_TIED,
      W_SPARSE
   } weight_style_type;

   typedef struct {
      req_type data;
      bit      drain;  // hold this transaction back until every result is in
   } pending_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // stimulus and expectations
   pending_type      pending[$];
   rsp_type          expected_rsp[$];
   logic [LAYER_W-1:0] hot_layer[HOT_LAYERS];

   // shadow of the block's state, updated as each transaction is accepted
   logic [THR_W-1:0]    thr_tab[STORE_DEPTH];
   logic [MK_W-1:0]     mk_tab[STORE_DEPTH];
   logic [WEIGHT_W-1:0] wbuf[MAX_EXPERTS];
   logic [63:0]         wsum;
   int unsigned         wcount;
   bit                  bad_flag;

   // bookkeeping
   int items_accepted  = 0;
   int results_checked = 0;
   int error_count     = 0;
   int n_events        = 0;
   int n_writes        = 0;
   int n_rejected      = 0;
   int n_clears        = 0;
   int n_too_many      = 0;
   int n_bad           = 0;
   int n_min_fill      = 0;
   int quiet_cycles    = 0;
   int hold_left       = 0;
   bit hold_done       = 1'b0;

   expert_route_threshold_skip dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------
   // shadow model of the block
   // ------------------------------------------------------------------

   function automatic void clear_policy();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         thr_tab[i] = '0;
         mk_tab[i]  = '0;
      end
   endfunction

   function automatic void route_reset();
      clear_policy();
      wsum     = '0;
      wcount   = 0;
      bad_flag = 1'b0;
   endfunction

   // decision for the event just closed by its last weight
   function automatic rsp_type decide_event(input logic [FAMILY_W-1:0] fam,
                                            input logic [LAYER_W-1:0] lay);
      rsp_type          res;
      int unsigned      n, idx, floor_keep, kept, best;
      logic [THR_W-1:0] thr;
      logic [31:0]      every;
      bit               chosen[MAX_EXPERTS];
      res   = '0;
      n     = wcount;
      every = (32'd1 << n) - 32'd1;
      // more weights than the buffer holds beats every other case
      if (n > MAX_EXPERTS) begin
         res.status = STATUS_TOO_MANY;
         n_too_many++;
         return res;
      end
      // control and unknown families pass everything through
      if (fam != FAMILY_CONTENT && fam != FAMILY_MEDIA) begin
         res.keep_mask = every[MASK_W-1:0];
         return res;
      end
      idx        = (int'(fam) - 1) * NUM_LAYERS + int'(lay);
      thr        = thr_tab[idx];
      floor_keep = 32'(mk_tab[idx]);
      // no policy stored: keep all, bad weights or not
      if (thr == '0) begin
         res.keep_mask = every[MASK_W-1:0];
         return res;
      end
      if (bad_flag) begin
         res.status = STATUS_BAD;
         n_bad++;
         return res;
      end
      if (wsum == '0) begin
         res.keep_mask = every[MASK_W-1:0];
         return res;
      end
      // mass test without the division: w * 2^16 >= thr * sum
      kept = 0;
      for (int unsigned i = 0; i < n; i++) begin
         chosen[i] = ({32'd0, wbuf[i]} << 16) >= 64'(thr) * wsum;
         if (chosen[i])
            kept++;
      end
      if (floor_keep < 1)
         floor_keep = 1;
      if (floor_keep > n)
         floor_keep = n;
      if (kept < floor_keep)
         n_min_fill++;
      // top up with the heaviest unkept experts, lowest index wins a tie
      while (kept < floor_keep) begin
         best = n;
         for (int unsigned i = 0; i < n; i++) begin
            if (!chosen[i] && (best == n || wbuf[i] > wbuf[best]))
               best = i;
         end
         chosen[best] = 1'b1;
         kept++;
      end
      for (int unsigned i = 0; i < n; i++)
         res.keep_mask[i] = chosen[i];
      res.skipped_count = SKIP_W'(n - kept);
      return res;
   endfunction

   function automatic void route_predict(input req_type r);
      rsp_type     res;
      int unsigned idx;
      res = '0;
      case (r.func)
         FUNC_WEIGHT: begin
            if (wcount < MAX_EXPERTS) begin
               wbuf[wcount] = r.weight;
               wsum         = wsum + 64'(r.weight);
               wcount++;
            end else
               wcount = MAX_EXPERTS + 1;
            if (r.weight_bad)
               bad_flag = 1'b1;
            if (r.last) begin
               expected_rsp.push_back(decide_event(r.family, r.layer));
               wsum     = '0;
               wcount   = 0;
               bad_flag = 1'b0;
               n_events++;
            end
         end
         FUNC_WRITE: begin
            n_writes++;
            if ((r.family != FAMILY_CONTENT && r.family != FAMILY_MEDIA) || r.layer == '0
                || r.threshold > THR_ONE || r.keep_floor == '0 || r.keep_floor > MK_LIMIT) begin
               res.status = STATUS_INVALID;
               n_rejected++;
            end else begin
               idx          = (int'(r.family) - 1) * NUM_LAYERS + int'(r.layer);
               thr_tab[idx] = r.threshold;
               mk_tab[idx]  = r.keep_floor;
               res.status   = STATUS_OK;
            end
            expected_rsp.push_back(res);
         end
         FUNC_CLEAR: begin
            clear_policy();
            n_clears++;
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus construction
   // ------------------------------------------------------------------

   function automatic req_type noise_req();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic void queue_item(input req_type r);
      pending.push_back('{data: r, drain: 1'b0});
   endfunction

   function automatic void queue_func(input logic [FUNC_W-1:0] f);
      req_type r;
      r      = noise_req();
      r.func = f;
      queue_item(r);
   endfunction

   function automatic void queue_write(input logic [FAMILY_W-1:0] fam,
                                       input logic [LAYER_W-1:0] lay,
                                       input logic [THR_W-1:0] thr,
                                       input logic [MK_W-1:0] mk);
      req_type r;
      r            = noise_req();
      r.func       = FUNC_WRITE;
      r.family     = fam;
      r.layer      = lay;
      r.threshold  = thr;
      r.keep_floor = mk;
      queue_item(r);
   endfunction

   // family and layer only matter on the last weight, so earlier ones carry noise there
   function automatic void queue_weight(input logic [FAMILY_W-1:0] fam,
                                        input logic [LAYER_W-1:0] lay,
                                        input logic [WEIGHT_W-1:0] w,
                                        input bit bad, input bit fin);
      req_type r;
      r            = noise_req();
      r.func       = FUNC_WEIGHT;
      r.weight     = w;
      r.weight_bad = bad;
      r.last       = fin;
      if (fin) begin
         r.family = fam;
         r.layer  = lay;
      end
      queue_item(r);
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight(input weight_style_type style);
      int unsigned sel;
      sel = $urandom_range(3);
      case (style)
         W_WIDE:   return $urandom;
         W_NARROW: return $urandom_range(1000);
         W_TIED: begin
            if (sel == 0)
               return '0;
            else if (sel == 1)
               return 32'd7;
            else if (sel == 2)
               return 32'h0001_0000;
            return '1;
         end
         default:  return (sel == 0) ? $urandom : '0;
      endcase
   endfunction

   function automatic logic [THR_W-1:0] pick_threshold();
      case ($urandom_range(9))
         0:       return '0;
         1:       return THR_ONE;
         2, 3:    return THR_W'($urandom_range(1, 8192));
         default: return THR_W'($urandom_range(1, 65536));
      endcase
   endfunction

   function automatic logic [MK_W-1:0] pick_min_keep();
      case ($urandom_range(9))
         0:       return MK_LIMIT;
         1:       return MK_W'($urandom_range(1, 256));
         default: return MK_W'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [FAMILY_W-1:0] policy_family();
      return ($urandom_range(1) == 0) ? FAMILY_CONTENT : FAMILY_MEDIA;
   endfunction

   function automatic void queue_random_event();
      logic [FAMILY_W-1:0] fam;
      logic [LAYER_W-1:0]  lay;
      weight_style_type    style;
      int unsigned         n, bad_at, roll;
      roll = $urandom_range(9);
      if (roll == 0)
         fam = FAMILY_CONTROL;
      else if (roll == 1)
         fam = FAMILY_UNUSED;
      else
         fam = policy_family();
      lay  = ($urandom_range(99) < 85) ? hot_layer[$urandom_range(HOT_LAYERS - 1)]
                                       : 8'($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 4)
         n = $urandom_range(MAX_EXPERTS + 1, MAX_EXPERTS + 4);  // overflows the buffer
      else if (roll < 20)
         n = $urandom_range(9, MAX_EXPERTS);
      else
         n = $urandom_range(1, 8);
      bad_at = ($urandom_range(99) < 6) ? $urandom_range(n - 1) : n;
      style  = weight_style_type'($urandom_range(3));
      for (int unsigned i = 0; i < n; i++) begin
         queue_weight(fam, lay, pick_weight(style), i == bad_at, i == n - 1);
         // a table clear or an unused code landing inside an open event
         if (i != n - 1 && $urandom_range(99) < 2)
            queue_func(($urandom_range(1) == 0) ? FUNC_CLEAR : FUNC_UNUSED);
      end
   endfunction

   // idling per phase of the run, chosen from how far the stimulus has got
   function automatic int unsigned send_idle_pct();
      if (items_accepted < ITEM_TARGET / 3)
         return 29;
      else if (items_accepted < 2 * ITEM_TARGET / 3)
         return 85;
      return 0;
   endfunction

   function automatic int unsigned recv_idle_pct();
      if (items_accepted < ITEM_TARGET / 3)
         return 85;
      else if (items_accepted < 2 * ITEM_TARGET / 3)
         return 29;
      return 0;
   endfunction

   // ------------------------------------------------------------------
   // driver: one transaction at a time from the pending queue
   // ------------------------------------------------------------------

   always @(posedge clock) begin : driver
      pending_type nxt;
      bit          took;
      if (reset) begin
         req_valid <= 1'b0;
         route_reset();
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            route_predict(req_data);
            items_accepted++;
         end
         // a stalled transaction stays put; otherwise decide what to offer next
         if (!req_valid || took) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct()
                && (!pending[0].drain || expected_rsp.size() == 0)) begin
               nxt = pending.pop_front();
               req_valid <= 1'b1;
               req_data  <= nxt.data;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: checks each result transaction and drives the stall
   // ------------------------------------------------------------------

   task automatic compare_field(input string what, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset)
         rsp_stall <= 1'b0;
      else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_rsp.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: unexpected result, expected none actual %h", $time, rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               compare_field("keep_mask", 32'(want.keep_mask), 32'(rsp_data.keep_mask));
               compare_field("skipped_count", 32'(want.skipped_count),
                             32'(rsp_data.skipped_count));
               compare_field("status", 32'(want.status), 32'(rsp_data.status));
            end
         end
         // one long hold-off late in the run, while the sender keeps offering
         if (!hold_done && items_accepted >= 5 * ITEM_TARGET / 6) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct());
      end
   end

   // ------------------------------------------------------------------
   // watchdog: too long without any transaction on either side
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ------------------------------------------------------------------
   // stimulus, reset and end of run
   // ------------------------------------------------------------------

   initial begin : stimulus
      int unsigned pick;
      hot_layer[0] = 8'd255;
      for (int i = 1; i < HOT_LAYERS; i++)
         hot_layer[i] = 8'($urandom_range(1, 254));

      // directed: field extremes, rejected writes, each decision path
      queue_write(FAMILY_CONTENT, 8'd1, THR_ONE, MK_LIMIT);
      queue_write(FAMILY_MEDIA, 8'd255, 17'd1, 9'd1);
      queue_write(FAMILY_CONTROL, 8'd5, 17'd100, 9'd4);     // control family not storable
      queue_write(FAMILY_CONTENT, 8'd0, 17'd100, 9'd4);     // layer zero
      queue_write(FAMILY_MEDIA, 8'd9, 17'h1FFFF, 9'd4);     // threshold above 1.0
      queue_write(FAMILY_CONTENT, 8'd9, 17'd100, 9'd0);     // min keep of zero
      queue_write(FAMILY_MEDIA, 8'd9, 17'd100, 9'h1FF);     // min keep too big
      queue_write(FAMILY_UNUSED, 8'd9, 17'd100, 9'd4);      // unknown family
      queue_weight(FAMILY_CONTENT, 8'd1, '1, 1'b0, 1'b1);   // single full-scale weight
      queue_weight(FAMILY_MEDIA, 8'd255, '0, 1'b0, 1'b0);   // zeros fail even a tiny threshold
      queue_weight(FAMILY_MEDIA, 8'd255, 32'd5, 1'b0, 1'b0);
      queue_weight(FAMILY_MEDIA, 8'd255, '0, 1'b0, 1'b1);
      queue_weight(FAMILY_CONTROL, 8'd3, 32'd123, 1'b1, 1'b1);  // control keeps all despite bad
      queue_weight(FAMILY_CONTENT, 8'd7, 32'd9, 1'b1, 1'b1);    // no policy keeps all despite bad
      queue_weight(FAMILY_CONTENT, 8'd1, 32'd40, 1'b0, 1'b0);
      queue_weight(FAMILY_CONTENT, 8'd1, 32'd60, 1'b1, 1'b1);   // bad weight under a policy
      queue_weight(FAMILY_CONTENT, 8'd1, '0, 1'b0, 1'b1);       // zero sum
      queue_func(FUNC_UNUSED);
      queue_func(FUNC_CLEAR);
      queue_write(FAMILY_CONTENT, 8'd1, THR_ONE, 9'd3);
      queue_weight(FAMILY_CONTENT, 8'd1, 32'd5, 1'b0, 1'b0);    // min keep fill with a tie
      queue_weight(FAMILY_CONTENT, 8'd1, 32'd9, 1'b0, 1'b0);
      queue_weight(FAMILY_CONTENT, 8'd1, 32'd9, 1'b0, 1'b0);
      queue_weight(FAMILY_CONTENT, 8'd1, 32'd1, 1'b0, 1'b1);
      queue_weight(FAMILY_MEDIA, 8'd255, 32'd1, 1'b0, 1'b1);    // policy gone after the clear

      // random: mostly well-formed events against a handful of busy layers
      while (pending.size() < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            if ($urandom_range(4) == 0)
               queue_func(FUNC_WRITE);
            else
               queue_write(policy_family(), hot_layer[$urandom_range(HOT_LAYERS - 1)],
                           pick_threshold(), pick_min_keep());
         end else if (pick < 14)
            queue_func(FUNC_CLEAR);
         else if (pick < 16)
            queue_func(FUNC_UNUSED);
         else
            queue_random_event();
      end

      // the sender waits for the block to drain at a couple of points
      pending[pending.size() / 2].drain     = 1'b1;
      pending[3 * pending.size() / 4].drain = 1'b1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d transactions: %0d events, %0d policy writes (%0d rejected), %0d clears",
               items_accepted, n_events, n_writes, n_rejected, n_clears);
      $display("%0d results checked: %0d overflowed, %0d bad weight, %0d needed min keep fill",
               results_checked, n_too_many, n_bad, n_min_fill);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
